[src/gclc_pkg.sv]
// Shared types and constants for the greedy limited-supply coin change block.
`timescale 1ns / 1ps

package gclc_pkg;

  localparam int unsigned IndexW          = 4;
  localparam int unsigned EntryCap        = 1 << IndexW;
  localparam int unsigned ValueW          = 16;
  localparam int unsigned AmountW         = 32;
  localparam int unsigned CfgW            = 5;
  localparam int unsigned MaxKindsDefault = 16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_CHANGE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_EXACT    = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_NO_EXACT = 2'd2
  } gclc_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_MUL,
    S_SUM_ADD,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL_SUB,
    S_SUB,
    S_EMIT
  } gclc_state_e;

endpackage

[src/gclc_div.sv]
// Restoring divider, one quotient bit per cycle, amount by coin face value.
`timescale 1ns / 1ps

module gclc_div import gclc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AmountW-1:0] dividend_i,
  input  logic [ValueW-1:0]  divisor_i,
  output logic               done_o,
  output logic [AmountW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(AmountW);

  logic               busy_q;
  logic               done_q;
  logic [StepW-1:0]   step_q;
  logic [AmountW-1:0] quo_q;
  logic [ValueW-1:0]  rem_q;
  logic [ValueW-1:0]  divisor_q;
  logic [ValueW:0]    trial;
  logic [ValueW:0]    diff;
  logic               fits;

  assign trial = {rem_q, quo_q[AmountW-1]};
  assign fits  = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + StepW'(1);
      if (step_q == StepW'(AmountW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[AmountW-2:0], fits};
      rem_q <= fits ? diff[ValueW-1:0] : trial[ValueW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/greedy_limited_coin_change.sv]
// Top level of the greedy coin change engine with a limited supply per coin kind.
`timescale 1ns / 1ps

// A load request (command 0) writes one coin kind and gives no result. A change
// request (command 1) first sums value times count over the kinds in use through
// the shared 16x16 multiplier. If the amount exceeds that total or no kind is in
// use, one result ends the request; else it walks the kinds from the highest slot
// down, each kind with a non-zero value going through the 32-step bit-serial
// divider, and one result per kind follows, one a cycle. Busy stays high throughout.
// Results appear for exactly one cycle under res_valid_o and cannot be held off, so
// the receiver must take them as they come.

module greedy_limited_coin_change import gclc_pkg::*; #(
  parameter int unsigned MAX_KINDS = MaxKindsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [IndexW-1:0]  entry_index_i,
  input  logic [ValueW-1:0]  coin_value_i,
  input  logic [ValueW-1:0]  coin_count_i,
  input  logic [AmountW-1:0] amount_i,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output logic               res_valid_o,
  output logic [ValueW-1:0]  kind_value_o,
  output logic [ValueW-1:0]  coins_used_o,
  output logic [1:0]         status_o,
  output logic [AmountW-1:0] remainder_o,
  output logic               last_o
);

  localparam int unsigned TableDepth = (MAX_KINDS < EntryCap) ? MAX_KINDS : EntryCap;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned TotalW     = 2 * ValueW + IdxW;

  gclc_state_e state_q, state_d;

  logic [CfgW-1:0]     kinds_q;
  logic [CntW-1:0]     n_q, n_d;
  logic [CntW-1:0]     i_q, i_d;
  logic [AmountW-1:0]  money_q, money_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic [2*ValueW-1:0] prod_q;
  logic [ValueW-1:0]   c_q, c_d;

  logic [ValueW-1:0] value_q [TableDepth];
  logic [ValueW-1:0] count_q [TableDepth];
  logic [ValueW-1:0] used_q  [TableDepth];

  logic               res_valid_q, res_valid_d;
  logic [ValueW-1:0]  kind_value_q, kind_value_d;
  logic [ValueW-1:0]  coins_used_q, coins_used_d;
  gclc_status_e       status_q, status_d;
  logic [AmountW-1:0] remainder_q, remainder_d;
  logic               last_q, last_d;

  logic               accept;
  logic               load_we;
  logic               used_we;
  logic [ValueW-1:0]  used_d;
  logic [IdxW-1:0]    ridx;
  logic [ValueW-1:0]  cur_v;
  logic [ValueW-1:0]  cur_c;
  logic [ValueW-1:0]  mul_b;
  logic [2*ValueW-1:0] product;
  logic               bottom;
  logic               short_fail;
  logic               over_total;
  logic               div_start;
  logic               div_done;
  logic [AmountW-1:0] quotient;
  logic [CntW-1:0]    n_clip;

  assign accept  = start && !busy;
  assign load_we = accept && (command_i == CMD_LOAD)
                   && ({1'b0, entry_index_i} < (IndexW + 1)'(TableDepth));
  assign busy    = (state_q != S_IDLE);

  assign ridx   = i_q[IdxW-1:0];
  assign cur_v  = value_q[ridx];
  assign cur_c  = count_q[ridx];
  assign bottom = (i_q == '0);

  assign n_clip = (kinds_q > CfgW'(TableDepth)) ? CntW'(TableDepth) : CntW'(kinds_q);

  assign mul_b   = (state_q == S_MUL_SUB) ? c_q : cur_c;
  assign product = {{ValueW{1'b0}}, cur_v} * {{ValueW{1'b0}}, mul_b};

  assign over_total = TotalW'(money_q) > total_q;
  assign short_fail = over_total || (n_q == '0);

  gclc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (money_q),
    .divisor_i  (cur_v),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (command_i == CMD_CHANGE)) begin
          state_d = S_SUM_MUL;
        end
      end
      S_SUM_MUL: begin
        state_d = (i_q == n_q) ? S_CHECK : S_SUM_ADD;
      end
      S_SUM_ADD: begin
        state_d = S_SUM_MUL;
      end
      S_CHECK: begin
        state_d = short_fail ? S_IDLE : S_DIV_START;
      end
      S_DIV_START: begin
        if (cur_v == '0) begin
          state_d = bottom ? S_EMIT : S_DIV_START;
        end else begin
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_MUL_SUB;
        end
      end
      S_MUL_SUB: begin
        state_d = S_SUB;
      end
      S_SUB: begin
        state_d = bottom ? S_EMIT : S_DIV_START;
      end
      S_EMIT: begin
        state_d = bottom ? S_IDLE : S_EMIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    n_d          = n_q;
    i_d          = i_q;
    money_d      = money_q;
    total_d      = total_q;
    c_d          = c_q;
    used_we      = 1'b0;
    used_d       = c_q;
    div_start    = 1'b0;
    res_valid_d  = 1'b0;
    kind_value_d = kind_value_q;
    coins_used_d = coins_used_q;
    status_d     = status_q;
    remainder_d  = remainder_q;
    last_d       = last_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (command_i == CMD_CHANGE)) begin
          money_d = amount_i;
          n_d     = n_clip;
          i_d     = '0;
          total_d = '0;
        end
      end
      S_SUM_ADD: begin
        total_d = total_q + TotalW'(prod_q);
        i_d     = i_q + CntW'(1);
      end
      S_CHECK: begin
        if (short_fail) begin
          res_valid_d  = 1'b1;
          kind_value_d = '0;
          coins_used_d = '0;
          status_d     = over_total ? STATUS_SHORT : STATUS_EXACT;
          remainder_d  = money_q;
          last_d       = 1'b1;
        end else begin
          i_d = n_q - CntW'(1);
        end
      end
      S_DIV_START: begin
        if (cur_v == '0) begin
          used_we = 1'b1;
          used_d  = '0;
          i_d     = bottom ? (n_q - CntW'(1)) : (i_q - CntW'(1));
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          c_d = (quotient > AmountW'(cur_c)) ? cur_c : quotient[ValueW-1:0];
        end
      end
      S_MUL_SUB: begin
        used_we = 1'b1;
        used_d  = c_q;
      end
      S_SUB: begin
        money_d = money_q - AmountW'(prod_q);
        i_d     = bottom ? (n_q - CntW'(1)) : (i_q - CntW'(1));
      end
      S_EMIT: begin
        res_valid_d  = 1'b1;
        kind_value_d = cur_v;
        coins_used_d = used_q[ridx];
        status_d     = (money_q == '0) ? STATUS_EXACT : STATUS_NO_EXACT;
        remainder_d  = money_q;
        last_d       = bottom;
        if (!bottom) begin
          i_d = i_q - CntW'(1);
        end
      end
      default: begin
        n_d = n_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kinds_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        kinds_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    i_q          <= i_d;
    money_q      <= money_d;
    total_q      <= total_d;
    c_q          <= c_d;
    prod_q       <= product;
    kind_value_q <= kind_value_d;
    coins_used_q <= coins_used_d;
    status_q     <= status_d;
    remainder_q  <= remainder_d;
    last_q       <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      value_q[entry_index_i[IdxW-1:0]] <= coin_value_i;
      count_q[entry_index_i[IdxW-1:0]] <= coin_count_i;
    end
    if (used_we) begin
      used_q[ridx] <= used_d;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign kind_value_o = kind_value_q;
  assign coins_used_o = coins_used_q;
  assign status_o     = status_q;
  assign remainder_o  = remainder_q;
  assign last_o       = last_q;

endmodule

[bench/gclc_checker.sv]
// Watches the coin change channels, predicts each change request's results and compares them.
`timescale 1ns / 1ps

module gclc_checker import gclc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               command_i,
  input  logic [IndexW-1:0]  entry_index_i,
  input  logic [ValueW-1:0]  coin_value_i,
  input  logic [ValueW-1:0]  coin_count_i,
  input  logic [AmountW-1:0] amount_i,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               res_valid_i,
  input  logic [ValueW-1:0]  kind_value_i,
  input  logic [ValueW-1:0]  coins_used_i,
  input  logic [1:0]         status_i,
  input  logic [AmountW-1:0] remainder_i,
  input  logic               last_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        results_o
);

  localparam int TableDepth = (MaxKindsDefault < EntryCap) ? MaxKindsDefault : EntryCap;

  typedef struct packed {
    logic [ValueW-1:0]  kind_value;
    logic [ValueW-1:0]  coins_used;
    gclc_status_e       status;
    logic [AmountW-1:0] remainder;
    logic               last;
  } change_result_t;

  logic [ValueW-1:0] face_value [EntryCap];
  logic [ValueW-1:0] supply [EntryCap];
  logic [CfgW-1:0]   active_kinds;
  change_result_t    expected_change [$];
  change_result_t    want;

  task automatic report_mismatch(input string what, input logic [AmountW-1:0] got,
                                 input logic [AmountW-1:0] wanted);
    mismatches_o++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, wanted);
  endtask

  function automatic void predict_change(input logic [AmountW-1:0] amount);
    int                 n;
    logic [63:0]        held;
    logic [AmountW-1:0] left;
    logic [AmountW-1:0] take;
    logic [ValueW-1:0]  used [EntryCap];
    change_result_t     r;
    n = (int'(active_kinds) > TableDepth) ? TableDepth : int'(active_kinds);
    held = '0;
    for (int i = 0; i < n; i++) held += 64'(face_value[i]) * 64'(supply[i]);
    if (64'(amount) > held || n == 0) begin
      r.kind_value = '0;
      r.coins_used = '0;
      r.status     = (64'(amount) > held) ? STATUS_SHORT : STATUS_EXACT;
      r.remainder  = amount;
      r.last       = 1'b1;
      expected_change.push_back(r);
      return;
    end
    left = amount;
    for (int i = n - 1; i >= 0; i--) begin
      take = '0;
      if (face_value[i] != '0) begin
        take = left / AmountW'(face_value[i]);
        if (take > AmountW'(supply[i])) take = AmountW'(supply[i]);
        left -= take * AmountW'(face_value[i]);
      end
      used[i] = take[ValueW-1:0];
    end
    for (int i = n - 1; i >= 0; i--) begin
      r.kind_value = face_value[i];
      r.coins_used = used[i];
      r.status     = (left == '0) ? STATUS_EXACT : STATUS_NO_EXACT;
      r.remainder  = left;
      r.last       = (i == 0);
      expected_change.push_back(r);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      active_kinds = '0;
      expected_change.delete();
    end else begin
      if (res_valid_i) begin
        results_o++;
        if (expected_change.size() == 0) begin
          report_mismatch("result with no change request outstanding",
                          AmountW'(kind_value_i), '0);
        end else begin
          want = expected_change.pop_front();
          if (kind_value_i !== want.kind_value)
            report_mismatch("kind_value", AmountW'(kind_value_i), AmountW'(want.kind_value));
          if (coins_used_i !== want.coins_used)
            report_mismatch("coins_used", AmountW'(coins_used_i), AmountW'(want.coins_used));
          if (status_i !== want.status)
            report_mismatch("status", AmountW'(status_i), AmountW'(want.status));
          if (remainder_i !== want.remainder)
            report_mismatch("remainder", remainder_i, want.remainder);
          if (last_i !== want.last)
            report_mismatch("last", AmountW'(last_i), AmountW'(want.last));
        end
      end
      if (cfg_we_i) active_kinds = cfg_wdata_i;
      if (start_i && !busy_i) begin
        if (command_i == CMD_LOAD) begin
          if (int'(entry_index_i) < TableDepth) begin
            face_value[entry_index_i] = coin_value_i;
            supply[entry_index_i]     = coin_count_i;
          end
        end else begin
          predict_change(amount_i);
        end
      end
    end
    pending_o = expected_change.size();
  end

endmodule

[bench/tb.sv]
// Stimulus and verdict for the greedy limited-supply coin change block.
`timescale 1ns / 1ps

module tb;
  import gclc_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned ItemTarget = 470;
  localparam int unsigned DrainWait  = 700;

  localparam logic [ValueW-1:0] DemoValue [EntryCap] = '{
    16'd0, 16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100,
    16'd200, 16'd500, 16'd1000, 16'd2000, 16'd5000, 16'd10000, 16'd20000, 16'd65535
  };
  localparam logic [ValueW-1:0] DemoCount [EntryCap] = '{
    16'd5, 16'd3, 16'd2, 16'd1, 16'd4, 16'd0, 16'd2, 16'd65535,
    16'd1, 16'd3, 16'd2, 16'd1, 16'd0, 16'd2, 16'd1, 16'd65535
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               command_i;
  logic [IndexW-1:0]  entry_index_i;
  logic [ValueW-1:0]  coin_value_i;
  logic [ValueW-1:0]  coin_count_i;
  logic [AmountW-1:0] amount_i;
  logic               cfg_we_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               res_valid_o;
  logic [ValueW-1:0]  kind_value_o;
  logic [ValueW-1:0]  coins_used_o;
  logic [1:0]         status_o;
  logic [AmountW-1:0] remainder_o;
  logic               last_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;

  logic [ValueW-1:0] stock_value [EntryCap];
  logic [ValueW-1:0] stock_count [EntryCap];
  int unsigned       kinds_now;
  int unsigned       burst_left;
  int unsigned       loads;
  int unsigned       changes;
  int unsigned       kind_settings;
  int unsigned       quiet;

  greedy_limited_coin_change DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .entry_index_i (entry_index_i),
    .coin_value_i  (coin_value_i),
    .coin_count_i  (coin_count_i),
    .amount_i      (amount_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .res_valid_o   (res_valid_o),
    .kind_value_o  (kind_value_o),
    .coins_used_o  (coins_used_o),
    .status_o      (status_o),
    .remainder_o   (remainder_o),
    .last_o        (last_o)
  );

  gclc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command_i),
    .entry_index_i (entry_index_i),
    .coin_value_i  (coin_value_i),
    .coin_count_i  (coin_count_i),
    .amount_i      (amount_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .res_valid_i   (res_valid_o),
    .kind_value_i  (kind_value_o),
    .coins_used_i  (coins_used_o),
    .status_i      (status_o),
    .remainder_i   (remainder_o),
    .last_i        (last_o),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .results_o     (results)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || cfg_we_i) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic issue(input logic cmd, input logic [IndexW-1:0] idx,
                       input logic [ValueW-1:0] val, input logic [ValueW-1:0] cnt,
                       input logic [AmountW-1:0] amt);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    entry_index_i <= idx;
    coin_value_i  <= val;
    coin_count_i  <= cnt;
    amount_i      <= amt;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (cmd == CMD_LOAD) begin
      stock_value[idx] = val;
      stock_count[idx] = cnt;
      loads++;
    end else begin
      changes++;
    end
  endtask

  // hold the sender until the block has drained, then write the kind count
  task automatic set_kinds(input int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CfgW'(n);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    kinds_now = n;
    kind_settings++;
  endtask

  function automatic logic [AmountW-1:0] pick_amount();
    int unsigned n;
    logic [63:0] held;
    logic [63:0] combo;
    n = (kinds_now > EntryCap) ? EntryCap : kinds_now;
    held  = '0;
    combo = '0;
    for (int i = 0; i < n; i++) begin
      held  += 64'(stock_value[i]) * 64'(stock_count[i]);
      combo += 64'($urandom_range(0, stock_count[i])) * 64'(stock_value[i]);
    end
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return (combo > 64'hFFFF_FFFF) ? $urandom() : combo[31:0];
      4, 5:    return (held > 64'hFFFF_FFFF) ? $urandom() : $urandom_range(0, held[31:0]);
      6:       return (held > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : held[31:0];
      7:       return (held >= 64'hFFFF_FF00) ? $urandom() : held[31:0] + $urandom_range(1, 200);
      8:       return $urandom();
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned span;
    int          prev;
    int          val;
    logic        ascending;
    logic        wide;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    command_i     = CMD_LOAD;
    entry_index_i = '0;
    coin_value_i  = '0;
    coin_count_i  = '0;
    amount_i      = '0;
    burst_left    = 0;
    kinds_now     = 0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no kinds in use straight after reset
    issue(CMD_CHANGE, '0, '0, '0, 32'd0);
    issue(CMD_CHANGE, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < EntryCap; i++)
      issue(CMD_LOAD, IndexW'(i), DemoValue[i], DemoCount[i], $urandom());
    set_kinds(16);
    issue(CMD_CHANGE, '0, '0, '0, 32'hFFFF_FFFF);
    issue(CMD_CHANGE, '0, '0, '0, 32'd0);
    issue(CMD_CHANGE, '0, '0, '0, 32'd8);
    set_kinds(3);
    issue(CMD_CHANGE, '0, '0, '0, 32'd8);
    issue(CMD_CHANGE, '0, '0, '0, 32'd7);
    set_kinds(31);
    issue(CMD_CHANGE, '0, '0, '0, 32'd123456);

    while (loads + changes < ItemTarget) begin
      case ($urandom_range(0, 19))
        0:          n = 0;
        1:          n = $urandom_range(17, 31);
        2, 3, 4:    n = $urandom_range(7, 16);
        default:    n = $urandom_range(1, 6);
      endcase
      set_kinds(n);
      span = (n > EntryCap) ? EntryCap : n;
      if ($urandom_range(0, 3) != 0) begin
        ascending = ($urandom_range(0, 4) != 0);
        wide      = ($urandom_range(0, 3) == 0);
        prev      = 0;
        for (int i = 0; i < span; i++) begin
          if (ascending) begin
            val = prev + $urandom_range(1, wide ? 16000 : 40);
            if (val > 65535) val = $urandom_range(1, 65535);
          end else begin
            val = $urandom_range(1, 65535);
          end
          prev = val;
          issue(CMD_LOAD, IndexW'(i), ValueW'(val),
                ($urandom_range(0, 3) == 0) ? ValueW'($urandom_range(0, 65535))
                                            : ValueW'($urandom_range(0, 12)),
                $urandom());
        end
      end
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 7) == 0)
          issue(CMD_LOAD, IndexW'($urandom_range(0, 15)), ValueW'($urandom_range(0, 65535)),
                ValueW'($urandom_range(0, 65535)), $urandom());
        else
          issue(CMD_CHANGE, IndexW'($urandom()), ValueW'($urandom()), ValueW'($urandom()),
                pick_amount());
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    $display("Covered %0d coin kind loads and %0d change requests under %0d kind counts,",
             loads, changes, kind_settings);
    $display("checking %0d results field by field with %0d mismatches.", results, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
